// ===== src/pat_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pat_pkg;

	localparam int CHAN_W = 8;
	localparam int CODE_W = 32;
	localparam int CNT_W  = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = 2'd3;

	// Transaction kinds on the item channel.
	localparam logic KIND_ADD = 1'b0;
	localparam logic KIND_ACK = 1'b1;

	// Stored fields of one ring slot; the valid mark is kept apart so that
	// only it needs a reset.
	typedef struct packed {
		logic              direct;
		logic [CHAN_W-1:0] channel;
		logic [CODE_W-1:0] code;
	} entry_t;

	// Outcome of an acknowledgement lookup.
	typedef struct packed {
		logic              found;
		logic [CHAN_W-1:0] channel;
		logic [CNT_W-1:0]  count;
	} ack_res_t;

endpackage

`default_nettype wire

// ===== src/pat_item_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pat_item_if;
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic [pat_pkg::CHAN_W-1:0] channel;
	logic                      direct;
	logic [pat_pkg::CODE_W-1:0] code;

	modport source (output valid, kind, channel, direct, code, input ready);
	modport sink   (input valid, kind, channel, direct, code, output ready);
endinterface

`default_nettype wire

// ===== src/pat_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pat_result_if;
	logic                       valid;
	logic                       ready;
	logic [pat_pkg::CHAN_W-1:0] confirmed_channel;
	logic [pat_pkg::CNT_W-1:0]  older_same_channel;

	modport source (output valid, confirmed_channel, older_same_channel, input ready);
	modport sink   (input valid, confirmed_channel, older_same_channel, output ready);
endinterface

`default_nettype wire

// ===== src/pending_ack_tracker_core.sv =====
// Path: an accepted acknowledgement transaction passes the input register, then
// the result register, before its confirmation is offered.
// Throughput: one transaction per cycle, with lookup, popcount and slot update
// in one pass; a hit waits in the input register while a result is held.
// Reset: arst_n clears every valid mark, the write pointer and both handshake
// stages at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module pending_ack_tracker_core #(
	parameter int ENTRIES = 4
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	pat_item_if.sink    item,
	pat_result_if.source result
);
	import pat_pkg::*;

	localparam int PTR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// Input register stage. Every accepted transaction waits here; its effect
	// on the ring is applied as it leaves the stage, so the next transaction
	// always sees the updated ring.
	logic              valid_s1;
	logic              kind_s1;
	logic [CHAN_W-1:0] channel_s1;
	logic              direct_s1;
	logic [CODE_W-1:0] code_s1;

	// Result register, which decouples the result side from the item side.
	logic              out_valid_q;
	logic [CHAN_W-1:0] out_channel_q;
	logic [CNT_W-1:0]  out_count_q;

	logic [ENTRIES-1:0] entry_valid;
	entry_t             entries [ENTRIES];
	logic [PTR_W-1:0]   wr_ptr;
	ack_res_t           ack_res;
	logic [ENTRIES-1:0] hit_mask;
	entry_t             wr_entry;

	logic s1_emit;
	logic out_free;
	logic s1_go;
	logic wr_en;
	logic clr_en;

	// An acknowledgement that hits must find room in the result register
	// before it may leave the input stage; everything else leaves at once.
	assign s1_emit  = valid_s1 & (kind_s1 == KIND_ACK) & ack_res.found;
	assign out_free = !out_valid_q || result.ready;
	assign s1_go    = valid_s1 & (!s1_emit | out_free);

	assign item.ready = !valid_s1 || s1_go;

	assign wr_en  = s1_go & (kind_s1 == KIND_ADD);
	assign clr_en = s1_go & s1_emit;

	assign wr_entry.direct  = direct_s1;
	assign wr_entry.channel = channel_s1;
	assign wr_entry.code    = code_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			kind_s1    <= item.kind;
			channel_s1 <= item.channel;
			direct_s1  <= item.direct;
			code_s1    <= item.code;
		end
	end

	pat_ring #(
		.ENTRIES (ENTRIES)
	) u_ring (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_entry    (wr_entry),
		.clr_en      (clr_en),
		.clr_mask    (hit_mask),
		.entry_valid (entry_valid),
		.entries     (entries),
		.wr_ptr      (wr_ptr)
	);

	pat_match #(
		.ENTRIES (ENTRIES)
	) u_match (
		.entry_valid (entry_valid),
		.entries     (entries),
		.wr_ptr      (wr_ptr),
		.code        (code_s1),
		.res         (ack_res),
		.hit_mask    (hit_mask)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_emit) begin
			out_channel_q <= ack_res.channel;
			out_count_q   <= ack_res.count;
		end
	end

	assign result.valid              = out_valid_q;
	assign result.confirmed_channel  = out_channel_q;
	assign result.older_same_channel = out_count_q;

	// At most one slot is ever selected by a lookup.
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(hit_mask))
		else $error("more than one slot selected by an acknowledgement");

	// A confirmed slot is no longer valid in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		clr_en |=> ((entry_valid & $past(hit_mask)) == '0))
		else $error("confirmed slot still valid");

	// Each add transaction moves the write pointer on.
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (wr_ptr != $past(wr_ptr)))
		else $error("write pointer did not advance");

	// A fresh result only ever comes from an acknowledgement.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_free && s1_emit) |-> (kind_s1 == KIND_ACK))
		else $error("result loaded from an add transaction");

endmodule

`default_nettype wire

// ===== src/pat_ring.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pat_ring #(
	parameter int ENTRIES = 4
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        wr_en,
	input  wire pat_pkg::entry_t                             wr_entry,
	input  wire logic                                        clr_en,
	input  wire logic [ENTRIES-1:0]                          clr_mask,
	output logic      [ENTRIES-1:0]                          entry_valid,
	output pat_pkg::entry_t                                  entries [ENTRIES],
	output logic      [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_ptr
);
	import pat_pkg::*;

	localparam int PTR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ENTRIES - 1);

	logic [ENTRIES-1:0] valid_q;
	logic [PTR_W-1:0]   ptr_q;
	entry_t             entry_q [ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ptr_q   <= '0;
		end else begin
			if (wr_en) begin
				valid_q[ptr_q] <= 1'b1;
				ptr_q          <= (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);
			end else if (clr_en) begin
				valid_q <= valid_q & ~clr_mask;
			end
		end
	end

	// Slot contents matter only while the valid mark is set.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[ptr_q] <= wr_entry;
		end
	end

	assign entry_valid = valid_q;
	assign entries     = entry_q;
	assign wr_ptr      = ptr_q;

endmodule

`default_nettype wire

// ===== src/pat_match.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pat_match #(
	parameter int ENTRIES = 4
) (
	input  wire logic [ENTRIES-1:0]                               entry_valid,
	input  wire pat_pkg::entry_t                                  entries [ENTRIES],
	input  wire logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_ptr,
	input  wire logic [pat_pkg::CODE_W-1:0]                       code,
	output pat_pkg::ack_res_t                                     res,
	output logic      [ENTRIES-1:0]                               hit_mask
);
	import pat_pkg::*;

	localparam int PTR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SUM_W = $clog2(ENTRIES + 1);

	logic [ENTRIES-1:0] match_vec;
	logic [ENTRIES-1:0] elig_vec;
	logic [PTR_W-1:0]   age [ENTRIES];
	logic [PTR_W-1:0]   hit_age;
	logic [CHAN_W-1:0]  hit_chan;
	logic [SUM_W-1:0]   sum;
	logic [PTR_W:0]     diff;

	always_comb begin
		diff = '0;
		for (int k = 0; k < ENTRIES; k++) begin
			match_vec[k] = entry_valid[k] & entries[k].direct & (entries[k].code == code);
			// Distance of slot k from the oldest ring position.
			diff = {1'b0, PTR_W'(k)} - {1'b0, wr_ptr};
			if (PTR_W'(k) < wr_ptr) begin
				diff = diff + (PTR_W + 1)'(ENTRIES);
			end
			age[k] = diff[PTR_W-1:0];
		end
	end

	// Lowest-indexed matching slot wins.
	assign hit_mask = match_vec & (~match_vec + ENTRIES'(1));

	always_comb begin
		hit_age  = '0;
		hit_chan = '0;
		for (int k = 0; k < ENTRIES; k++) begin
			hit_age  = hit_age  | ({PTR_W{hit_mask[k]}} & age[k]);
			hit_chan = hit_chan | ({CHAN_W{hit_mask[k]}} & entries[k].channel);
		end
	end

	always_comb begin
		sum = '0;
		for (int k = 0; k < ENTRIES; k++) begin
			elig_vec[k] = entry_valid[k] & entries[k].direct &
				(entries[k].channel == hit_chan) & (age[k] < hit_age);
			sum = sum + SUM_W'(elig_vec[k]);
		end
		res.found   = |match_vec;
		res.channel = hit_chan;
		if (sum > SUM_W'(CNT_MAX)) begin
			res.count = CNT_MAX;
		end else begin
			res.count = CNT_W'(sum);
		end
	end

endmodule

`default_nettype wire
